FILE: hdl/assert_macros.svh
// assertion helpers used by the top-level file that checks this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define IKR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define IKR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/ikr_pkg.sv
`default_nettype none

package ikr_pkg;

    localparam int WIDTH   = 64;
    localparam int FIELD_W = 64;
    localparam int DEG_W   = 7;
    // for degree two or more the root never needs more than this many bits
    localparam int HALF    = (WIDTH + 1) / 2;
    localparam int BIT_W   = $clog2(HALF);
    localparam int SUM_W   = WIDTH + HALF;
    localparam int PC_W    = 4;

    typedef logic [PC_W-1:0] t_addr;

    localparam t_addr A_IDLE   = 4'd0;
    localparam t_addr A_CHECK  = 4'd1;
    localparam t_addr A_START  = 4'd2;
    localparam t_addr A_TEST   = 4'd3;
    localparam t_addr A_CAND   = 4'd4;
    localparam t_addr A_MUL_LO = 4'd5;
    localparam t_addr A_MUL_HI = 4'd6;
    localparam t_addr A_CMP    = 4'd7;
    localparam t_addr A_NEXT   = 4'd8;
    localparam t_addr A_FINISH = 4'd9;
    localparam t_addr A_ACCEPT = 4'd10;
    localparam t_addr A_DONE   = 4'd15;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_CAND,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_ACCEPT,
        OP_DEC,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_SPECIAL,
        C_SKIP,
        C_CNT_ZERO,
        C_FITS,
        C_B_NZ,
        C_BUSY
    } t_cond;

    typedef struct packed {
        logic  rdy;
        t_op   op;
        t_cond cond;
        t_addr target;
    } t_ctl;

    typedef struct packed {
        logic req;
        logic busy;
        logic special;
        logic skip;
        logic cnt_zero;
        logic fits;
        logic b_nz;
    } t_stat;

endpackage

`default_nettype wire

FILE: hdl/ikr_if.sv
`default_nettype none

interface ikr_in_if;
    logic                        valid;
    logic                        ready;
    logic [ikr_pkg::FIELD_W-1:0] value;
    logic [ikr_pkg::DEG_W-1:0]   degree;

    modport source (output valid, output value, output degree, input ready);
    modport sink   (input valid, input value, input degree, output ready);
endinterface

interface ikr_out_if;
    logic                        valid;
    logic                        ready;
    logic [ikr_pkg::FIELD_W-1:0] root_floor;
    logic [ikr_pkg::FIELD_W-1:0] remainder;

    modport source (output valid, output root_floor, output remainder, input ready);
    modport sink   (input valid, input root_floor, input remainder, output ready);
endinterface

`default_nettype wire

FILE: hdl/ikr_sequencer.sv
`default_nettype none

module ikr_sequencer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ikr_pkg::t_stat i_stat,
    output ikr_pkg::t_ctl       o_ctl,
    output ikr_pkg::t_addr      o_pc
);

    // control store: one word per step
    function automatic ikr_pkg::t_ctl rom(input ikr_pkg::t_addr a);
        ikr_pkg::t_ctl w;
        unique case (a)
            ikr_pkg::A_IDLE:
                w = '{1'b1, ikr_pkg::OP_LOAD,   ikr_pkg::C_NO_REQ,   ikr_pkg::A_IDLE};
            ikr_pkg::A_CHECK:
                w = '{1'b0, ikr_pkg::OP_NOP,    ikr_pkg::C_SPECIAL,  ikr_pkg::A_DONE};
            ikr_pkg::A_START:
                w = '{1'b0, ikr_pkg::OP_INIT,   ikr_pkg::C_NEVER,    ikr_pkg::A_IDLE};
            ikr_pkg::A_TEST:
                w = '{1'b0, ikr_pkg::OP_NOP,    ikr_pkg::C_SKIP,     ikr_pkg::A_NEXT};
            ikr_pkg::A_CAND:
                w = '{1'b0, ikr_pkg::OP_CAND,   ikr_pkg::C_NEVER,    ikr_pkg::A_IDLE};
            ikr_pkg::A_MUL_LO:
                w = '{1'b0, ikr_pkg::OP_MUL_LO, ikr_pkg::C_CNT_ZERO, ikr_pkg::A_ACCEPT};
            ikr_pkg::A_MUL_HI:
                w = '{1'b0, ikr_pkg::OP_MUL_HI, ikr_pkg::C_NEVER,    ikr_pkg::A_IDLE};
            ikr_pkg::A_CMP:
                w = '{1'b0, ikr_pkg::OP_ACC,    ikr_pkg::C_FITS,     ikr_pkg::A_MUL_LO};
            ikr_pkg::A_NEXT:
                w = '{1'b0, ikr_pkg::OP_DEC,    ikr_pkg::C_B_NZ,     ikr_pkg::A_TEST};
            ikr_pkg::A_FINISH:
                w = '{1'b0, ikr_pkg::OP_NOP,    ikr_pkg::C_ALWAYS,   ikr_pkg::A_DONE};
            ikr_pkg::A_ACCEPT:
                w = '{1'b0, ikr_pkg::OP_ACCEPT, ikr_pkg::C_ALWAYS,   ikr_pkg::A_NEXT};
            // falls through to address zero once the result register is free
            ikr_pkg::A_DONE:
                w = '{1'b0, ikr_pkg::OP_OUT,    ikr_pkg::C_BUSY,     ikr_pkg::A_DONE};
            default:
                w = '{1'b0, ikr_pkg::OP_NOP,    ikr_pkg::C_ALWAYS,   ikr_pkg::A_IDLE};
        endcase
        return w;
    endfunction

    ikr_pkg::t_addr r_pc;
    ikr_pkg::t_addr n_pc;
    logic           w_take;

    assign o_ctl = rom(r_pc);
    assign o_pc  = r_pc;

    always_comb begin
        unique case (o_ctl.cond)
            ikr_pkg::C_NEVER:    w_take = 1'b0;
            ikr_pkg::C_ALWAYS:   w_take = 1'b1;
            ikr_pkg::C_NO_REQ:   w_take = !i_stat.req;
            ikr_pkg::C_SPECIAL:  w_take = i_stat.special;
            ikr_pkg::C_SKIP:     w_take = i_stat.skip;
            ikr_pkg::C_CNT_ZERO: w_take = i_stat.cnt_zero;
            ikr_pkg::C_FITS:     w_take = i_stat.fits;
            ikr_pkg::C_B_NZ:     w_take = i_stat.b_nz;
            ikr_pkg::C_BUSY:     w_take = i_stat.busy;
            default:             w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = w_take ? o_ctl.target : r_pc + ikr_pkg::t_addr'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ikr_pkg::A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ikr_datapath.sv
`default_nettype none

module ikr_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ikr_pkg::t_ctl i_ctl,
    output ikr_pkg::t_stat     o_stat,
    ikr_in_if.sink             i_req,
    ikr_out_if.source          o_res
);

    localparam int W  = ikr_pkg::WIDTH;
    localparam int H  = ikr_pkg::HALF;
    localparam int BW = ikr_pkg::BIT_W;
    localparam int KW = ikr_pkg::DEG_W;
    localparam int SW = ikr_pkg::SUM_W;
    localparam int FW = ikr_pkg::FIELD_W;

    logic [W-1:0]    r_n;
    logic [KW-1:0]   r_k;
    logic [BW-1:0]   r_b;
    logic [H-1:0]    r_root;
    logic [H-1:0]    r_cand;
    logic [W-1:0]    r_acc;
    logic [KW-1:0]   r_cnt;
    logic [2*H-1:0]  r_pp;
    logic [SW-1:0]   r_sum;
    logic [W-1:0]    r_pw;
    logic            r_ovalid;
    logic [W-1:0]    r_oroot;
    logic [W-1:0]    r_orem;

    logic [H-1:0]    w_half;
    logic [2*H-1:0]  w_prod;
    logic [BW+KW-1:0] w_bk;
    logic [H-1:0]    w_cand;
    logic            w_fire;
    logic            w_busy;
    logic            w_load_out;
    logic            w_deg0;
    logic            w_trivial;

    // power so far times candidate, split at the half word
    assign w_half = (i_ctl.op == ikr_pkg::OP_MUL_HI) ? H'(r_acc[W-1:H]) : r_acc[H-1:0];
    assign w_prod = w_half * r_cand;
    assign w_bk   = r_b * r_k;
    assign w_cand = r_root | (H'(1) << r_b);

    assign w_fire     = i_req.valid && i_req.ready;
    assign w_busy     = r_ovalid && !o_res.ready;
    assign w_load_out = (i_ctl.op == ikr_pkg::OP_OUT) && !w_busy;
    assign w_deg0     = (r_k == '0);
    assign w_trivial  = (r_n == '0) || (r_k == KW'(1));

    assign i_req.ready = i_ctl.rdy && i_rst_n;

    always_comb begin
        o_stat.req      = i_req.valid;
        o_stat.busy     = w_busy;
        o_stat.special  = w_deg0 || w_trivial;
        // a set bit b gives at least 2^(b*k), too big for the value
        o_stat.skip     = w_bk >= (BW+KW)'(W);
        o_stat.cnt_zero = (r_cnt == '0);
        o_stat.fits     = r_sum <= SW'(r_n);
        o_stat.b_nz     = (r_b != '0);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            ikr_pkg::OP_NOP: begin
            end
            ikr_pkg::OP_LOAD: begin
                if (w_fire) begin
                    r_n <= i_req.value[W-1:0];
                    r_k <= i_req.degree;
                end
            end
            ikr_pkg::OP_INIT: begin
                r_b    <= BW'(H - 1);
                r_root <= '0;
                r_pw   <= '0;
            end
            ikr_pkg::OP_CAND: begin
                r_cand <= w_cand;
                r_acc  <= W'(w_cand);
                r_cnt  <= r_k - KW'(1);
            end
            ikr_pkg::OP_MUL_LO: begin
                r_pp <= w_prod;
            end
            ikr_pkg::OP_MUL_HI: begin
                r_sum <= {w_prod, {H{1'b0}}} + SW'(r_pp);
                r_cnt <= r_cnt - KW'(1);
            end
            ikr_pkg::OP_ACC: begin
                r_acc <= r_sum[W-1:0];
            end
            ikr_pkg::OP_ACCEPT: begin
                r_root <= r_cand;
                r_pw   <= r_acc;
            end
            ikr_pkg::OP_DEC: begin
                r_b <= r_b - BW'(1);
            end
            ikr_pkg::OP_OUT: begin
                if (w_load_out) begin
                    priority if (w_deg0) begin
                        r_oroot <= '0;
                        r_orem  <= '0;
                    end else if (w_trivial) begin
                        r_oroot <= r_n;
                        r_orem  <= '0;
                    end else begin
                        r_oroot <= W'(r_root);
                        r_orem  <= r_n - r_pw;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.root_floor = FW'(r_oroot);
    assign o_res.remainder  = FW'(r_orem);

endmodule

`default_nettype wire

FILE: hdl/integer_kth_root_remainder.sv
`default_nettype none

// Floor k-th root of an unsigned value with remainder value - root^k, one result per
// request. A small control store steps a datapath with one half-word multiplier: the
// root is built one bit at a time from the top, each trial power formed by k-1
// multiplies, each split into a low-half and a high-half step, plus a compare, stopping
// as soon as it passes the value. Degree zero, degree one and a zero value go from the
// check step straight to the done step. Otherwise a bit position whose trial power must
// exceed the value is skipped without a multiply; a tested one runs the multiply loop.
// A new request is taken while the previous result still waits in the output register.
`include "assert_macros.svh"

module integer_kth_root_remainder (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ikr_in_if.sink     i_req,
    ikr_out_if.source  o_res
);

    ikr_pkg::t_ctl  w_ctl;
    ikr_pkg::t_stat w_stat;
    ikr_pkg::t_addr w_pc;

    ikr_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_pc    (w_pc)
    );

    ikr_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_res   (o_res)
    );

    `IKR_ASSERT(a_accept_to_check, (i_req.valid && i_req.ready) |=> (w_pc == ikr_pkg::A_CHECK), "request accepted but sequencer did not advance")
    `IKR_ASSERT(a_result_from_done, $rose(o_res.valid) |-> ($past(w_pc) == ikr_pkg::A_DONE), "result raised outside the done step")
    `IKR_ASSERT(a_pc_mapped, (w_pc <= ikr_pkg::A_ACCEPT) || (w_pc == ikr_pkg::A_DONE), "sequencer reached an unused step")
    `IKR_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!o_res.valid && (w_pc == ikr_pkg::A_IDLE)), "reset left control state set")

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int            FW        = ikr_pkg::FIELD_W;
    localparam int            DW        = ikr_pkg::DEG_W;
    localparam logic [FW-1:0] MAX_VAL   = {FW{1'b1}};
    localparam int            HOLD_LEN  = 2000;
    localparam int            IDLE_LIM  = 60000;
    localparam int            MAX_SHOWN = 10;

    typedef struct {
        logic [FW-1:0] value;
        logic [DW-1:0] degree;
        logic [FW-1:0] root;
        logic [FW-1:0] rem;
    } t_root_result;

    typedef enum int {RX_FULL, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ikr_in_if  req_if ();
    ikr_out_if res_if ();

    integer_kth_root_remainder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_root_result expected_roots[$];
    int           mismatch_cnt  = 0;
    int           burst_left    = 0;
    bit           long_hold_req = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [FW-1:0] int_pow(input logic [FW-1:0] base, input int k);
        logic [FW-1:0] acc;
        acc = FW'(1);
        for (int i = 0; i < k; i++) acc = acc * base;
        return acc;
    endfunction

    // bitwise search from the top; trial powers stop before they can overflow
    function automatic t_root_result predict_root(input logic [FW-1:0] value,
                                                  input logic [DW-1:0] degree);
        t_root_result  res;
        logic [FW-1:0] r;
        logic [FW-1:0] cand;
        logic [FW-1:0] quot;
        logic [FW-1:0] acc;
        bit            fits;
        int            k;
        res.value  = value;
        res.degree = degree;
        k = int'(degree);
        if (k == 0) begin
            res.root = '0;
            res.rem  = '0;
        end else if (value == '0 || k == 1) begin
            res.root = value;
            res.rem  = '0;
        end else begin
            r = '0;
            for (int b = FW - 1; b >= 0; b--) begin
                cand = r | (FW'(1) << b);
                quot = value / cand;
                acc  = FW'(1);
                fits = 1'b1;
                for (int i = 0; i < k && fits; i++) begin
                    if (acc > quot) fits = 1'b0;
                    else acc = acc * cand;
                end
                if (fits) r = cand;
            end
            res.root = r;
            res.rem  = value - int_pow(r, k);
        end
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_req(input logic [FW-1:0] value, input logic [DW-1:0] degree);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 99) < 30) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 60))
                                                     : int'($urandom_range(1, 16));
        end
        burst_left--;
        req_if.valid  <= 1'b1;
        req_if.value  <= value;
        req_if.degree <= degree;
        do @(posedge i_clk); while (!req_if.ready);
        expected_roots.push_back(predict_root(value, degree));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (expected_roots.size() != 0);
    endtask

    task automatic test_special_cases();
        send_req(64'd0, 7'd0);
        send_req(MAX_VAL, 7'd0);
        send_req(64'd0, 7'd5);
        send_req(64'd0, 7'd127);
        send_req(MAX_VAL, 7'd1);
        send_req(64'd12345, 7'd1);
        send_req(MAX_VAL, 7'd2);
        send_req(MAX_VAL, 7'd3);
        send_req(MAX_VAL, 7'd63);
        send_req(MAX_VAL, 7'd64);
        send_req(MAX_VAL, 7'd65);
        send_req(MAX_VAL, 7'd127);
        send_req(64'd1, 7'd2);
        send_req(64'd2, 7'd2);
        send_req(64'd3, 7'd2);
        send_req(64'd4, 7'd2);
        send_req(64'h8000_0000_0000_0000, 7'd63);
        send_req(64'h7FFF_FFFF_FFFF_FFFF, 7'd63);
        send_req(64'hFFFF_FFFE_0000_0001, 7'd2);
        send_req(64'hFFFF_FFFE_0000_0000, 7'd2);
        send_req(64'd18446724184312856125, 7'd3);
        send_req(64'd18446724184312856124, 7'd3);
        send_req(64'd7, 7'd3);
        send_req(64'd5, 7'd100);
        wait_drained();
    endtask

    // values next to exact powers, where the compare against the radicand is tight
    task automatic test_perfect_powers(input int count);
        int            k;
        t_root_result  top;
        logic [FW-1:0] max_root;
        logic [FW-1:0] r;
        logic [FW-1:0] p;
        int            offs;
        for (int n = 0; n < count; n++) begin
            k = ($urandom_range(0, 9) < 3) ? int'($urandom_range(2, 64))
                                           : int'($urandom_range(2, 6));
            top      = predict_root(MAX_VAL, DW'(k));
            max_root = top.root;
            if ($urandom_range(0, 3) == 0 && max_root > 20) r = FW'($urandom_range(1, 20));
            else r = FW'($urandom_range(1, max_root[31:0]));
            p    = int_pow(r, k);
            offs = int'($urandom_range(0, 2));
            if (offs == 1 && p != MAX_VAL) p = p + FW'(1);
            else if (offs == 2) p = p - FW'(1);
            send_req(p, DW'(k));
        end
        wait_drained();
    endtask

    task automatic test_random_mix(input int count);
        logic [FW-1:0] value;
        logic [DW-1:0] degree;
        int            pick;
        for (int n = 0; n < count; n++) begin
            pick = int'($urandom_range(0, 9));
            if (pick < 5) value = {$urandom, $urandom};
            else if (pick < 8) value = {$urandom, $urandom} >> $urandom_range(1, 63);
            else value = FW'($urandom_range(0, 300));
            pick = int'($urandom_range(0, 99));
            if (pick < 60) degree = DW'($urandom_range(2, 5));
            else if (pick < 75) degree = DW'($urandom_range(6, 64));
            else if (pick < 85) degree = DW'($urandom_range(65, 127));
            else if (pick < 95) degree = DW'($urandom_range(0, 1));
            else degree = DW'($urandom_range(0, 127));
            send_req(value, degree);
        end
        wait_drained();
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        burst_left    = 40;
        for (int n = 0; n < 16; n++) send_req({$urandom, $urandom}, DW'($urandom_range(0, 8)));
        wait_drained();
    endtask

    task automatic test_drain_pause();
        for (int g = 0; g < 10; g++) begin
            for (int n = 0; n < 3; n++) send_req({$urandom, $urandom}, DW'($urandom_range(2, 4)));
            wait_drained();
        end
    endtask

    // receiver ready pattern, with an occasional long hold-off on request
    initial begin : rx_ready_gen
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        mode      = RX_FULL;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = HOLD_LEN - 1;
                res_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = int'($urandom_range(64, 256));
                end
                mode_left--;
                case (mode)
                    RX_FULL:   res_if.ready <= 1'b1;
                    RX_COIN:   res_if.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   res_if.ready <= ((phase % 8) < 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_root_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_roots.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN)
                    $display("unexpected result: root %h rem %h",
                             res_if.root_floor, res_if.remainder);
            end else begin
                exp_res = expected_roots.pop_front();
                if (res_if.root_floor !== exp_res.root || res_if.remainder !== exp_res.rem) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN)
                        $display("mismatch value %h deg %0d: root exp %h got %h, rem exp %h got %h",
                                 exp_res.value, exp_res.degree, exp_res.root,
                                 res_if.root_floor, exp_res.rem, res_if.remainder);
                end
            end
        end
    end

    // watchdog on cycles with no progress on either channel
    always @(posedge i_clk) begin
        int idle_cycles;
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIM) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.value  = '0;
        req_if.degree = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_special_cases();
        test_perfect_powers(380);
        test_backpressure();
        test_random_mix(700);
        test_drain_pause();
        test_backpressure();

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_roots.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ikr_pkg.sv
hdl/ikr_if.sv
hdl/ikr_sequencer.sv
hdl/ikr_datapath.sv
hdl/integer_kth_root_remainder.sv
dv/tb_top.sv
